@@ rtl/md5_byte_stream_hash_defines.svh @@
// assertion macros for the md5 byte stream hash rtl
`ifndef MD5_BYTE_STREAM_HASH_DEFINES_SVH
`define MD5_BYTE_STREAM_HASH_DEFINES_SVH

// antecedent holds, consequent holds in the same cycle
`define MD5BS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define MD5BS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/md5bs_pkg.sv @@
// types, constants and round tables for the md5 byte stream hash
`default_nettype none
package md5bs_pkg;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] POS_LAST  = 6'd63;
    localparam logic [5:0] POS_LEN   = 6'd56;
    localparam logic [5:0] POS_BEFORE_LEN = 6'd55;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [1:0] WORD_LAST = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_PREP,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_abcd;

    localparam t_abcd CHAIN_INIT = '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROUND_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used by a round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = rnd[3:0];
        unique case (rnd[5:4])
            2'd0: idx = lo;
            2'd1: idx = 4'(lo * 4'd5 + 4'd1);
            2'd2: idx = 4'(lo * 4'd3 + 4'd5);
            2'd3: idx = 4'(lo * 4'd7);
            default: idx = lo;
        endcase
        return idx;
    endfunction

endpackage
`default_nettype wire

@@ rtl/md5bs_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module md5bs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

@@ rtl/md5bs_round.sv @@
// one md5 round: round function, constant add, rotate and state shift
`default_nettype none
module md5bs_round (
    input  wire md5bs_pkg::t_abcd i_state,
    input  wire logic [5:0]       i_round,
    input  wire logic [31:0]      i_word,
    output      md5bs_pkg::t_abcd o_state
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] dbl;
    logic [4:0]  shamt;

    always_comb begin
        unique case (i_round[5:4])
            2'd0: f = (i_state.b & i_state.c) | (~i_state.b & i_state.d);
            2'd1: f = (i_state.b & i_state.d) | (i_state.c & ~i_state.d);
            2'd2: f = i_state.b ^ i_state.c ^ i_state.d;
            2'd3: f = i_state.c ^ (i_state.b | ~i_state.d);
            default: f = '0;
        endcase
    end

    assign sum   = i_state.a + f + md5bs_pkg::ROUND_K[i_round] + i_word;
    assign shamt = md5bs_pkg::ROUND_S[{i_round[5:4], i_round[1:0]}];
    // rotate left by shifting the doubled word
    assign dbl   = {sum, sum} << shamt;

    always_comb begin
        o_state.a = i_state.d;
        o_state.d = i_state.c;
        o_state.c = i_state.b;
        o_state.b = i_state.b + dbl[63:32];
    end

endmodule
`default_nettype wire

@@ rtl/md5_byte_stream_hash.sv @@
// md5 hash over a byte stream with digest output as four words
//
// channel  dir  tdata                    tuser             tlast
// s        in   data_byte[7:0]           command[0]        -
// m        out  digest_word[31:0]        word_index[1:0]   last_word
//
// an append item writes one byte into the block; the item that fills a 64-byte
// block starts its compression in one shared round unit (load, 64 rounds, chain add)
// a finish item starts padding, one pad or length byte per cycle and a compression
// per filled block, then four digest words, one per cycle while m_tready is high
// reset sets the initial chaining words and a zero length; no clearing pass
// s_tready stays low while a block compresses, padding runs or words wait
`default_nettype none
`include "md5_byte_stream_hash_defines.svh"
module md5_byte_stream_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tuser,   // [0] command
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [31:0] o_m_tdata,   // [31:0] digest_word
    output      logic [1:0]  o_m_tuser,   // [1:0] word_index
    output      logic        o_m_tlast
);

    md5bs_pkg::t_state r_state, n_state;
    md5bs_pkg::t_abcd  r_chain, r_work, round_out;

    logic [63:0] r_bit_count;
    logic [63:0] r_len;
    logic [23:0] r_word;
    logic [5:0]  r_round;
    logic [1:0]  r_out_idx;
    logic        r_first, r_lenph, r_final;

    logic        s_hs, m_hs;
    logic [5:0]  pos;
    logic        place_en;
    logic [7:0]  place_byte;
    logic [7:0]  pad_byte;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;
    logic        wr_en;

    assign s_hs = i_s_tvalid && o_s_tready;
    assign m_hs = o_m_tvalid && i_m_tready;
    assign pos  = r_bit_count[8:3];

    // pad stream: marker byte, zeros up to the length field, then the length
    always_comb begin
        priority if (r_first) begin
            pad_byte = md5bs_pkg::PAD_BYTE;
        end else if (r_lenph) begin
            pad_byte = r_len[{pos[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = '0;
        end
    end

    always_comb begin
        o_s_tready = (r_state == md5bs_pkg::ST_IDLE);
        o_m_tvalid = (r_state == md5bs_pkg::ST_OUT);
        place_en   = (s_hs && i_s_tuser == md5bs_pkg::CMD_APPEND)
                     || (r_state == md5bs_pkg::ST_PAD);
        place_byte = (r_state == md5bs_pkg::ST_PAD) ? pad_byte : i_s_tdata;
        wr_en      = place_en && (pos[1:0] == 2'd3);
        // prefetch the word for the next round
        rd_addr    = (r_state == md5bs_pkg::ST_ROUND)
                     ? md5bs_pkg::msg_index(6'(r_round + 6'd1))
                     : md5bs_pkg::msg_index('0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            md5bs_pkg::ST_IDLE: begin
                if (s_hs) begin
                    if (i_s_tuser == md5bs_pkg::CMD_FINISH) begin
                        n_state = md5bs_pkg::ST_PAD;
                    end else if (pos == md5bs_pkg::POS_LAST) begin
                        n_state = md5bs_pkg::ST_PREP;
                    end
                end
            end
            md5bs_pkg::ST_PAD: begin
                if (pos == md5bs_pkg::POS_LAST) begin
                    n_state = md5bs_pkg::ST_PREP;
                end
            end
            md5bs_pkg::ST_PREP: n_state = md5bs_pkg::ST_ROUND;
            md5bs_pkg::ST_ROUND: begin
                if (r_round == md5bs_pkg::ROUND_LAST) begin
                    n_state = md5bs_pkg::ST_ADD;
                end
            end
            md5bs_pkg::ST_ADD: begin
                priority if (r_final) begin
                    n_state = md5bs_pkg::ST_OUT;
                end else if (r_lenph || r_first || r_len != r_bit_count) begin
                    n_state = md5bs_pkg::ST_PAD;
                end else begin
                    n_state = md5bs_pkg::ST_IDLE;
                end
            end
            md5bs_pkg::ST_OUT: begin
                if (m_hs && r_out_idx == md5bs_pkg::WORD_LAST) begin
                    n_state = md5bs_pkg::ST_IDLE;
                end
            end
            default: n_state = md5bs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= md5bs_pkg::ST_IDLE;
            r_chain     <= md5bs_pkg::CHAIN_INIT;
            r_bit_count <= '0;
            r_len       <= '0;
            r_round     <= '0;
            r_out_idx   <= '0;
            r_first     <= 1'b0;
            r_lenph     <= 1'b0;
            r_final     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (place_en) begin
                r_bit_count <= r_bit_count + 64'd8;
            end
            if (r_state == md5bs_pkg::ST_IDLE) begin
                // keeps the length copy equal to the count while appending
                r_len <= n_state == md5bs_pkg::ST_PAD ? r_bit_count : r_bit_count + 64'd8;
                if (s_hs && i_s_tuser == md5bs_pkg::CMD_FINISH) begin
                    r_first <= 1'b1;
                end
            end
            if (r_state == md5bs_pkg::ST_PAD) begin
                r_first <= 1'b0;
                if (!r_lenph && pos == md5bs_pkg::POS_BEFORE_LEN) begin
                    r_lenph <= 1'b1;
                end
                if (r_lenph && pos == md5bs_pkg::POS_LAST) begin
                    r_final <= 1'b1;
                end
            end
            if (r_state == md5bs_pkg::ST_ROUND) begin
                r_round <= 6'(r_round + 6'd1);
            end
            if (r_state == md5bs_pkg::ST_ADD) begin
                r_chain.a <= r_chain.a + r_work.a;
                r_chain.b <= r_chain.b + r_work.b;
                r_chain.c <= r_chain.c + r_work.c;
                r_chain.d <= r_chain.d + r_work.d;
            end
            if (m_hs) begin
                r_out_idx <= 2'(r_out_idx + 2'd1);
                if (r_out_idx == md5bs_pkg::WORD_LAST) begin
                    r_chain     <= md5bs_pkg::CHAIN_INIT;
                    r_bit_count <= '0;
                    r_len       <= '0;
                    r_lenph     <= 1'b0;
                    r_final     <= 1'b0;
                end
            end
        end
    end

    // payload registers; the top byte of a word goes straight to the ram
    always_ff @(posedge i_clk) begin
        if (place_en && pos[1:0] != 2'd3) begin
            r_word[{pos[1:0], 3'b000} +: 8] <= place_byte;
        end
        if (r_state == md5bs_pkg::ST_PREP) begin
            r_work <= r_chain;
        end else if (r_state == md5bs_pkg::ST_ROUND) begin
            r_work <= round_out;
        end
    end

    md5bs_ram #(
        .WIDTH(32),
        .DEPTH(16)
    ) u_block_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (pos[5:2]),
        .i_wr_data ({place_byte, r_word}),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    md5bs_round u_round (
        .i_state (r_work),
        .i_round (r_round),
        .i_word  (rd_data),
        .o_state (round_out)
    );

    always_comb begin
        unique case (r_out_idx)
            2'd0: o_m_tdata = r_chain.a;
            2'd1: o_m_tdata = r_chain.b;
            2'd2: o_m_tdata = r_chain.c;
            2'd3: o_m_tdata = r_chain.d;
            default: o_m_tdata = r_chain.a;
        endcase
        o_m_tuser = r_out_idx;
        o_m_tlast = (r_out_idx == md5bs_pkg::WORD_LAST);
    end

    `MD5BS_ASSERT_NOW(a_no_take_while_out, o_m_tvalid, !o_s_tready,
        "input taken during digest output")
    `MD5BS_ASSERT_NEXT(a_rounds_then_add,
        (r_state == md5bs_pkg::ST_ROUND) && (r_round == md5bs_pkg::ROUND_LAST),
        r_state == md5bs_pkg::ST_ADD, "rounds did not end in chain add")
    `MD5BS_ASSERT_NEXT(a_word_order, m_hs && !o_m_tlast,
        o_m_tvalid && (o_m_tuser == 2'($past(o_m_tuser) + 2'd1)),
        "digest words out of order")
    `MD5BS_ASSERT_NEXT(a_restart, m_hs && o_m_tlast,
        o_s_tready && (r_bit_count == '0) && (r_chain == md5bs_pkg::CHAIN_INIT),
        "no restart after digest")

endmodule
`default_nettype wire
